@@ rtl/swg_pkg.sv @@
package swg_pkg;

	localparam int unsigned WEIGHT_COUNT_DEFAULT = 1024;

	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 16;
	localparam int SCALE_W  = 16;
	localparam int OPCODE_W = 2;

	// running gradient sum, Q8.30
	localparam int SUM_W = 38;
	// the sum is split into a low unsigned half and a high signed half
	localparam int SUM_LO_W = 19;
	localparam int SUM_HI_W = SUM_W - SUM_LO_W;

	// shared multiplier: signed VALUE_W x signed MUL_B_W
	localparam int MUL_B_W = SUM_LO_W + 1;
	localparam int PROD_W  = VALUE_W + MUL_B_W;

	// scaled update before the shift
	localparam int UPD_W        = SCALE_W + SUM_W;
	localparam int UPDATE_SHIFT = 27;
	localparam int SHIFTED_W    = UPD_W - UPDATE_SHIFT;
	localparam int NEWW_W       = SHIFTED_W + 1;

	localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd4096;

	localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_MAC  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

	localparam logic signed [VALUE_W-1:0] WEIGHT_MAX = 16'sh7fff;
	localparam logic signed [VALUE_W-1:0] WEIGHT_MIN = 16'sh8000;

endpackage

@@ rtl/swg_mul.sv @@
module swg_mul
	import swg_pkg::*;
(
	input  logic                      clk,
	input  logic signed [VALUE_W-1:0] op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	output logic signed [PROD_W-1:0]  prod_q
);

	// one registered signed multiply per cycle
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

@@ rtl/swg_wmem.sv @@
module swg_wmem
	import swg_pkg::*;
#(
	parameter int unsigned DEPTH  = WEIGHT_COUNT_DEFAULT,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [VALUE_W-1:0] rdata_q
);

	logic [VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ rtl/scaled_weight_gradient_update.sv @@
// steps: a load writes the store in EXEC; a read goes EXEC, RESP, then the registered result;
// a term multiplies in EXEC and folds into the sum in ACC; the last term goes on to SLO, SHI, SADD, FIN
// busy holds off new commands until the current one is done; the one shared 16x20 multiplier
// serves the term product, then the two partial products
// reset: arst_n clears control, gradient sum and scale (to 1.0); weights undefined
// results are strobed for one cycle on result_valid; the receiver cannot stall
module scaled_weight_gradient_update
	import swg_pkg::*;
#(
	parameter int unsigned WEIGHT_COUNT = WEIGHT_COUNT_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// configuration write channel (update scale, Q4.12)
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic signed [SCALE_W-1:0] cfg_data,

	// command side
	input  logic                      start,
	output logic                      busy,
	input  logic [OPCODE_W-1:0]       opcode,
	input  logic [INDEX_W-1:0]        weight_index,
	input  logic signed [VALUE_W-1:0] delta,
	input  logic signed [VALUE_W-1:0] activation,
	input  logic signed [VALUE_W-1:0] load_value,
	input  logic                      last_term,

	// result side
	output logic                      result_valid,
	output logic [INDEX_W-1:0]        result_index,
	output logic signed [VALUE_W-1:0] weight_value,
	output logic                      saturated
);

	localparam int unsigned ADDR_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1; // dispatch, load write, term multiply, weight read
	localparam logic [2:0] ST_RESP = 3'd2; // read data ready
	localparam logic [2:0] ST_ACC  = 3'd3; // fold term product into the sum
	localparam logic [2:0] ST_SLO  = 3'd4; // scale x low half of sum
	localparam logic [2:0] ST_SHI  = 3'd5; // scale x high half of sum
	localparam logic [2:0] ST_SADD = 3'd6; // combine partial products
	localparam logic [2:0] ST_FIN  = 3'd7; // shift, add, clamp, write back

	logic [2:0] state_q;

	// accepted command
	logic [OPCODE_W-1:0]       op_q;
	logic [INDEX_W-1:0]        idx_q;
	logic signed [VALUE_W-1:0] delta_q;
	logic signed [VALUE_W-1:0] act_q;
	logic signed [VALUE_W-1:0] load_q;
	logic                      last_q;
	logic                      in_range_q;

	logic signed [SCALE_W-1:0] scale_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [UPD_W-1:0]   upd_q;

	// shared multiplier
	logic signed [VALUE_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	// weight store
	logic                mem_we;
	logic [VALUE_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0]   mem_addr;
	logic [VALUE_W-1:0]  rdata_q;

	// update arithmetic
	logic signed [VALUE_W-1:0]   old_w;
	logic signed [SHIFTED_W-1:0] shifted;
	logic signed [NEWW_W-1:0]    new_w_full;
	logic signed [VALUE_W-1:0]   new_w;
	logic                        new_sat;

	logic accept;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;

	// config register, written only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode;
			idx_q      <= weight_index;
			delta_q    <= delta;
			act_q      <= activation;
			load_q     <= load_value;
			last_q     <= last_term;
			in_range_q <= (32'(weight_index) < WEIGHT_COUNT);
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_EXEC: begin
				mul_a = delta_q;
				mul_b = MUL_B_W'(act_q);
			end
			ST_SLO: begin
				mul_a = scale_q;
				mul_b = $signed({1'b0, sum_q[SUM_LO_W-1:0]});
			end
			ST_SHI: begin
				mul_a = scale_q;
				mul_b = MUL_B_W'($signed(sum_q[SUM_W-1:SUM_LO_W]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	swg_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// weight store: read address follows the captured index, write on load or update
	assign mem_addr  = ADDR_W'(idx_q);
	assign mem_we    = in_range_q &&
		(((state_q == ST_EXEC) && (op_q == OP_LOAD)) || (state_q == ST_FIN));
	assign mem_wdata = (state_q == ST_FIN) ? new_w : load_q;

	swg_wmem #(
		.DEPTH  (WEIGHT_COUNT),
		.ADDR_W (ADDR_W)
	) u_wmem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_addr),
		.wdata   (mem_wdata),
		.raddr   (mem_addr),
		.rdata_q (rdata_q)
	);

	// entries past the store read as zero
	assign old_w = in_range_q ? $signed(rdata_q) : '0;

	// arithmetic shift gives round toward minus infinity
	assign shifted    = upd_q[UPD_W-1:UPDATE_SHIFT];
	assign new_w_full = NEWW_W'(old_w) + NEWW_W'(shifted);

	always_comb begin
		priority if (new_w_full > NEWW_W'(WEIGHT_MAX)) begin
			new_w   = WEIGHT_MAX;
			new_sat = 1'b1;
		end else if (new_w_full < NEWW_W'(WEIGHT_MIN)) begin
			new_w   = WEIGHT_MIN;
			new_sat = 1'b1;
		end else begin
			new_w   = new_w_full[VALUE_W-1:0];
			new_sat = 1'b0;
		end
	end

	// scaled update accumulator: low partial product, then high one shifted in
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SHI:  upd_q <= UPD_W'(prod_q);
			ST_SADD: upd_q <= upd_q + (UPD_W'(prod_q) <<< SUM_LO_W);
			default: upd_q <= upd_q;
		endcase
	end

	// sequencer and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						OP_READ: state_q <= ST_RESP;
						OP_MAC:  state_q <= ST_ACC;
						default: state_q <= ST_IDLE; // load done, unused code dropped
					endcase
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				ST_ACC: begin
					// wraps modulo 2^38 on very long runs
					sum_q   <= sum_q + SUM_W'(prod_q);
					state_q <= last_q ? ST_SLO : ST_IDLE;
				end
				ST_SLO: begin
					state_q <= ST_SHI;
				end
				ST_SHI: begin
					state_q <= ST_SADD;
				end
				ST_SADD: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					sum_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_RESP) || (state_q == ST_FIN);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RESP) begin
			result_index <= idx_q;
			weight_value <= old_w;
			saturated    <= 1'b0;
		end else if (state_q == ST_FIN) begin
			result_index <= idx_q;
			weight_value <= new_w;
			saturated    <= new_sat;
		end
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swg_pkg::*;

	// opcode with no operation behind it, the block must ignore it
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	localparam int STORE_DEPTH  = 1024;
	localparam int BATCH_LONG   = 64;
	// settle wait, long enough to cover the longest path, the last term
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 70;
	localparam int PHASE_COUNT   = 7;
	// phase that runs one batch long enough to wrap the 38-bit sum
	localparam int WRAP_PHASE    = 3;
	// phase with no random idle gaps from the sender
	localparam int BUSY_PHASE    = 2;

	typedef struct {
		logic [OPCODE_W-1:0]       op;
		logic [INDEX_W-1:0]        idx;
		logic signed [VALUE_W-1:0] dlt;
		logic signed [VALUE_W-1:0] act;
		logic signed [VALUE_W-1:0] ld;
		logic                      last;
	} command_t;

	typedef struct {
		logic [INDEX_W-1:0]        idx;
		logic signed [VALUE_W-1:0] value;
		logic                      sat;
	} weight_report_t;

	// directed row: command fields, then an optional typed-in report
	typedef struct {
		logic [OPCODE_W-1:0] op;
		int                  idx;
		int                  dlt;
		int                  act;
		int                  ld;
		bit                  last;
		bit                  typed;
		int                  e_idx;
		int                  e_val;
		bit                  e_sat;
	} directed_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic signed [SCALE_W-1:0] cfg_data = '0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [OPCODE_W-1:0]       opcode = OP_LOAD;
	logic [INDEX_W-1:0]        weight_index = '0;
	logic signed [VALUE_W-1:0] delta = '0;
	logic signed [VALUE_W-1:0] activation = '0;
	logic signed [VALUE_W-1:0] load_value = '0;
	logic                      last_term = 1'b0;
	logic                      result_valid;
	logic [INDEX_W-1:0]        result_index;
	logic signed [VALUE_W-1:0] weight_value;
	logic                      saturated;

	scaled_weight_gradient_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.weight_index (weight_index),
		.delta        (delta),
		.activation   (activation),
		.load_value   (load_value),
		.last_term    (last_term),
		.result_valid (result_valid),
		.result_index (result_index),
		.weight_value (weight_value),
		.saturated    (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the block's state
	logic signed [VALUE_W-1:0] weight_copy [STORE_DEPTH];
	logic signed [SUM_W-1:0]   term_sum = '0;
	logic signed [SCALE_W-1:0] scale_k = SCALE_RESET;

	// entries that have been loaded; only these are ever read or updated
	bit                        loaded [STORE_DEPTH];
	int                        loaded_list [$];

	weight_report_t            pending_reports [$];
	int                        mismatches = 0;
	int                        cycle_count = 0;
	int                        accepted_items = 0;
	bit                        idle_on = 1'b1;

	directed_row_t             directed [23];
	logic signed [SCALE_W-1:0] phase_scales [PHASE_COUNT];

	// state update and expected report for one accepted command
	function automatic bit predict_weight(input command_t c, output weight_report_t r);
		longint            prod;
		longint            scaled;
		longint            nw;
		logic signed [63:0] acc;
		r = '{idx: c.idx, value: '0, sat: 1'b0};
		case (c.op)
			OP_LOAD: begin
				weight_copy[c.idx] = c.ld;
				return 1'b0;
			end
			OP_READ: begin
				r.value = weight_copy[c.idx];
				return 1'b1;
			end
			OP_MAC: begin
				prod = longint'(c.dlt) * longint'(c.act);
				// sum wraps modulo 2^38
				acc = longint'(term_sum) + prod;
				term_sum = acc[SUM_W-1:0];
				if (!c.last)
					return 1'b0;
				// exact product, arithmetic shift rounds toward minus infinity
				scaled = (longint'(scale_k) * longint'(term_sum)) >>> UPDATE_SHIFT;
				nw = longint'(weight_copy[c.idx]) + scaled;
				if (nw > longint'(WEIGHT_MAX)) begin
					nw = longint'(WEIGHT_MAX);
					r.sat = 1'b1;
				end else if (nw < longint'(WEIGHT_MIN)) begin
					nw = longint'(WEIGHT_MIN);
					r.sat = 1'b1;
				end
				weight_copy[c.idx] = nw[VALUE_W-1:0];
				term_sum = '0;
				r.value = nw[VALUE_W-1:0];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic command_t make_cmd(input logic [OPCODE_W-1:0] op, input int idx,
		input int d, input int a, input int ld, input bit last);
		command_t c;
		c.op = op;
		c.idx = idx[INDEX_W-1:0];
		c.dlt = d[VALUE_W-1:0];
		c.act = a[VALUE_W-1:0];
		c.ld = ld[VALUE_W-1:0];
		c.last = last;
		return c;
	endfunction

	// full-scale values, small ones and plain random ones
	function automatic int pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return int'(WEIGHT_MAX);
		if (r < 16)
			return int'(WEIGHT_MIN);
		if (r < 30)
			return int'($urandom_range(0, 511)) - 256;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int pick_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// drive one command, hold it until the block takes it, then predict
	task automatic issue_command(input command_t c, input bit typed, input weight_report_t want);
		weight_report_t r;
		bit             has_report;
		if (idle_on && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.op;
		weight_index <= c.idx;
		delta <= c.dlt;
		activation <= c.act;
		load_value <= c.ld;
		last_term <= c.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// transfer done at this edge
		has_report = predict_weight(c, r);
		if (c.op == OP_LOAD && !loaded[c.idx]) begin
			loaded[c.idx] = 1'b1;
			loaded_list.push_back(int'(c.idx));
		end
		if (has_report)
			pending_reports.push_back(typed ? want : r);
		if (c.op != OP_UNUSED)
			accepted_items++;
	endtask

	// sender holds off until every report is in and the block has settled
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(input logic signed [SCALE_W-1:0] k);
		wait_idle();
		repeat ($urandom_range(0, 3)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		scale_k = k;
	endtask

	// one batch run: random content, last term lands on a loaded entry
	task automatic issue_batch(input int len, input bit extreme);
		weight_report_t none;
		command_t       c;
		bit             is_last;
		none = '{idx: '0, value: '0, sat: 1'b0};
		for (int k = 0; k < len; k++) begin
			is_last = (k == len - 1);
			if (extreme)
				c = make_cmd(OP_MAC, is_last ? pick_loaded() : int'($urandom_range(0, 1023)),
					int'(WEIGHT_MIN), int'(WEIGHT_MIN), pick_value(), is_last);
			else
				c = make_cmd(OP_MAC, is_last ? pick_loaded() : int'($urandom_range(0, 1023)),
					pick_value(), pick_value(), pick_value(), is_last);
			issue_command(c, 1'b0, none);
		end
	endtask

	// compare each strobed report with the oldest expectation
	always @(posedge clk) begin
		weight_report_t e;
		if (arst_n && result_valid) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("report with nothing expected, index", result_index, 0);
			end else begin
				e = pending_reports.pop_front();
				if (result_index !== e.idx)
					flag_mismatch("result_index", result_index, e.idx);
				if (weight_value !== e.value)
					flag_mismatch("weight_value", weight_value, e.value);
				if (saturated !== e.sat)
					flag_mismatch("saturated", saturated, e.sat);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		command_t       c;
		weight_report_t want;
		weight_report_t none;
		int unsigned    sel;
		int             target;

		none = '{idx: '0, value: '0, sat: 1'b0};

		// op, idx, delta, act, load, last, typed, exp idx, exp value, exp sat
		directed = '{
			// loads at both ends of the index range and value range
			'{OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_LOAD, 1023, 0, 0, 32767, 0, 0, 0, 0, 0},
			'{OP_LOAD, 5, 0, 0, -32768, 0, 0, 0, 0, 0},
			'{OP_READ, 1023, 0, 0, 0, 0, 1, 1023, 32767, 0},
			'{OP_READ, 5, 0, 0, 0, 0, 1, 5, -32768, 0},
			// open a run, then read and load in the middle of it
			'{OP_MAC, 300, 16384, 16384, 0, 0, 0, 0, 0, 0},
			'{OP_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0},
			'{OP_LOAD, 7, 0, 0, 100, 0, 0, 0, 0, 0},
			// sum kept through read/load; reset scale is 1.0: 0 + 0.5
			'{OP_MAC, 0, 16384, 16384, 0, 1, 1, 0, 16384, 0},
			// clip high and clip low
			'{OP_MAC, 1023, -32768, -32768, 0, 1, 1, 1023, 32767, 1},
			'{OP_MAC, 5, -32768, 32767, 0, 1, 1, 5, -32768, 1},
			// unused opcode leaves everything alone
			'{OP_UNUSED, 5, 1, 1, 1, 1, 0, 0, 0, 0},
			'{OP_READ, 5, 0, 0, 0, 0, 1, 5, -32768, 0},
			// tiny negative sum floors to -1
			'{OP_MAC, 0, -1, 1, 0, 1, 1, 0, 16383, 0},
			// only the last term's index counts
			'{OP_MAC, 1023, 3, 5, 0, 0, 0, 0, 0, 0},
			'{OP_MAC, 7, -3, 5, 0, 1, 1, 7, 100, 0},
			'{OP_READ, 1023, 0, 0, 0, 0, 1, 1023, 32767, 0},
			'{OP_LOAD, 512, 0, 0, 12345, 0, 0, 0, 0, 0},
			'{OP_MAC, 512, 1234, -2222, 0, 0, 0, 0, 0, 0},
			'{OP_MAC, 512, 30000, 29999, 0, 1, 0, 0, 0, 0},
			'{OP_MAC, 1023, 32767, 32767, 0, 1, 0, 0, 0, 0},
			'{OP_MAC, 0, -32768, -32768, 0, 0, 0, 0, 0, 0},
			'{OP_MAC, 0, -32768, -32768, 0, 1, 0, 0, 0, 0}
		};

		// scale extremes, zero, smallest steps, one random, back to 1.0
		phase_scales = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd0, SCALE_RESET};
		phase_scales[5] = 16'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed); i++) begin
			c = make_cmd(directed[i].op, directed[i].idx, directed[i].dlt, directed[i].act,
				directed[i].ld, directed[i].last);
			want = '{idx: directed[i].e_idx[INDEX_W-1:0], value: directed[i].e_val[VALUE_W-1:0],
				sat: directed[i].e_sat};
			issue_command(c, directed[i].typed, want);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_scale(phase_scales[p]);
			idle_on = (p != BUSY_PHASE);
			target = accepted_items + PHASE_ITEMS;
			while (accepted_items < target) begin
				sel = $urandom_range(0, 99);
				if (sel < 12) begin
					c = make_cmd(OP_LOAD, $urandom_range(0, 1023), pick_value(), pick_value(),
						pick_value(), $urandom_range(0, 1));
					issue_command(c, 1'b0, none);
				end else if (sel < 24) begin
					c = make_cmd(OP_READ, pick_loaded(), pick_value(), pick_value(),
						pick_value(), $urandom_range(0, 1));
					issue_command(c, 1'b0, none);
				end else if (sel < 84) begin
					// mostly short runs, now and then up to a full batch
					issue_batch(($urandom_range(0, 9) == 0) ? $urandom_range(5, BATCH_LONG)
						: $urandom_range(1, 4), 1'b0);
				end else if (sel < 92) begin
					c = make_cmd(OP_UNUSED, $urandom_range(0, 1023), pick_value(), pick_value(),
						pick_value(), $urandom_range(0, 1));
					issue_command(c, 1'b0, none);
				end else begin
					// stray term, folds into whatever run comes next
					c = make_cmd(OP_MAC, $urandom_range(0, 1023), pick_value(), pick_value(),
						pick_value(), 1'b0);
					issue_command(c, 1'b0, none);
				end
				if ($urandom_range(0, 99) < 2)
					wait_idle();
			end
			// full-scale terms past the safe batch length wrap the sum
			if (p == WRAP_PHASE)
				issue_batch(140, 1'b1);
		end

		wait_idle();
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
